FILE: rtl/mcesc_pkg.sv
// shared widths, constants and types of the esc pulse generator
package mcesc_pkg;

  localparam int NUM_MOTORS     = 4;
  localparam int DEBOUNCE_DEPTH = 10;

  localparam int SPEED_W   = 8;
  localparam int PULSE_W   = 16;
  localparam int PHASE_W   = 8;
  localparam int FRAMES_W  = 8;
  localparam int HOLD_W    = 10;
  localparam int POWER_W   = 16;
  localparam int PWR_FIELDS = 4;
  localparam int LINES_W   = 4;
  localparam int CH_W      = $clog2(NUM_MOTORS + 1);
  localparam int IDX_W     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int SLOT_W    = $clog2(DEBOUNCE_DEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  localparam logic [PHASE_W-1:0]  FRAME_TICKS_RST      = 8'd20;
  localparam logic [FRAMES_W-1:0] WATCHDOG_LIMIT_RST   = 8'd100;
  localparam logic [SPEED_W-1:0]  POWER_LIMIT_RST      = 8'd200;
  localparam logic [PULSE_W-1:0]  PULSE_BASE_RST       = 16'd2500;
  localparam logic [7:0]          PULSE_MULT_RST       = 8'd10;
  localparam logic [HOLD_W-1:0]   REPEAT_DELAY_RST     = 10'd500;
  localparam logic [HOLD_W-1:0]   REPEAT_STEP_BACK_RST = 10'd80;

  localparam logic [SPEED_W-1:0]  SPEED_STEP   = 8'd10;
  localparam logic [SPEED_W-1:0]  SPEED_UP_MAX = 8'd100;
  localparam logic [FRAMES_W-1:0] FRAMES_SAT   = 8'd255;
  localparam logic [HOLD_W-1:0]   HOLD_SAT     = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_TICKS      = 3'd0,
    REG_WATCHDOG_LIMIT   = 3'd1,
    REG_POWER_LIMIT      = 3'd2,
    REG_PULSE_BASE       = 3'd3,
    REG_PULSE_MULT       = 3'd4,
    REG_BUTTONS_ENABLE   = 3'd5,
    REG_REPEAT_DELAY     = 3'd6,
    REG_REPEAT_STEP_BACK = 3'd7
  } cfg_reg_t;

  // one debounce sample request from the pulse logic
  typedef struct packed {
    logic       fire;
    logic [1:0] sample;  // bit 1 up, bit 0 down
  } btn_ctrl_t;

  typedef struct packed {
    logic [HOLD_W-1:0] delay;
    logic [HOLD_W-1:0] step_back;
  } rpt_cfg_t;

endpackage

FILE: rtl/mcesc_buttons.sv
// button debounce, edge detect and auto-repeat stepping of motor zero speed
module mcesc_buttons
  import mcesc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  btn_ctrl_t          ctrl,
  input  rpt_cfg_t           rpt,
  input  logic [SPEED_W-1:0] speed_i,
  output logic [SPEED_W-1:0] speed_o
);

  typedef struct packed {
    logic              fire;
    logic [HOLD_W-1:0] cnt;
  } hold_res_t;

  logic [1:0]        hist_r [DEBOUNCE_DEPTH];
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [1:0]        stable_r;
  logic [1:0]        stable_nxt;
  logic [HOLD_W-1:0] hold_up_r;
  logic [HOLD_W-1:0] hold_up_nxt;
  logic [HOLD_W-1:0] hold_dn_r;
  logic [HOLD_W-1:0] hold_dn_nxt;

  function automatic logic [SPEED_W-1:0] step_up(input logic [SPEED_W-1:0] s);
    step_up = (s < SPEED_UP_MAX) ? s + SPEED_STEP : s;
  endfunction

  function automatic logic [SPEED_W-1:0] step_down(input logic [SPEED_W-1:0] s);
    step_down = (s > SPEED_STEP) ? s - SPEED_STEP : '0;
  endfunction

  function automatic hold_res_t hold_step(input logic [HOLD_W-1:0] cnt,
                                          input logic held,
                                          input rpt_cfg_t cfg);
    hold_res_t res;
    res.fire = 1'b0;
    res.cnt  = cnt;
    if (!held) begin
      res.cnt = '0;
    end else begin
      if (res.cnt > cfg.delay) begin
        res.fire = 1'b1;
        res.cnt  = (res.cnt > cfg.step_back) ? res.cnt - cfg.step_back : '0;
      end
      if (res.cnt < HOLD_SAT) res.cnt = res.cnt + 1'b1;
    end
    hold_step = res;
  endfunction

  hold_res_t hu;
  hold_res_t hd;
  logic [1:0] fresh;

  always_comb begin
    logic [SPEED_W-1:0] s;
    logic [1:0]         acc;
    acc = 2'b11;
    // history with the new sample already in its slot
    for (int i = 0; i < DEBOUNCE_DEPTH; i++) begin
      acc = acc & ((slot_r == SLOT_W'(i)) ? ctrl.sample : hist_r[i]);
    end
    stable_nxt = acc;
    fresh = ~stable_r & acc;
    s = speed_i;
    if (fresh[1]) s = step_up(s);
    else if (fresh[0]) s = step_down(s);
    hu = hold_step(hold_up_r, acc[1], rpt);
    if (hu.fire) s = step_up(s);
    hd = hold_step(hold_dn_r, acc[0], rpt);
    if (hd.fire) s = step_down(s);
    hold_up_nxt = hu.cnt;
    hold_dn_nxt = hd.cnt;
    speed_o = s;
    slot_nxt = (slot_r >= SLOT_W'(DEBOUNCE_DEPTH - 1)) ? '0 : slot_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEBOUNCE_DEPTH; i++) hist_r[i] <= '0;
      slot_r    <= '0;
      stable_r  <= '0;
      hold_up_r <= '0;
      hold_dn_r <= '0;
    end else if (ctrl.fire) begin
      hist_r[slot_r] <= ctrl.sample;
      slot_r    <= slot_nxt;
      stable_r  <= stable_nxt;
      hold_up_r <= hold_up_nxt;
      hold_dn_r <= hold_dn_nxt;
    end
  end

endmodule

FILE: rtl/multi_channel_esc_pulse_generator.sv
// top level of the four-channel esc pulse generator
//
// Input beats are either base-timer ticks (in_tuser 0, optionally with a
// millisecond strobe and raw button levels) or set-power commands (in_tuser 1).
// Every input beat produces exactly one output beat carrying the pulse line
// levels, the stored speed of motor zero and the watchdog flag, all taken
// after that beat's update.
// An accepted beat's result is registered and shows up on out_* in the next
// cycle. Throughput is one beat per cycle while the receiver keeps up; the
// whole update (pulse counter, frame phase, watchdog, 8x8 pulse width
// products, debounce) sits between the state and output registers.
// When the receiver stalls, the output register holds its beat and in_tready
// drops until it is taken; a beat is still accepted in the cycle the waiting
// one leaves.
// Configuration writes on cfg_* are always taken (cfg_ready high); the user must
// make them only while no beat is in flight, as the block does not enforce it.
// Reset (rst_n low, synchronous) loads the default register values, clears
// speeds, counters and debounce history, leaves all pulse lines idle and
// empties the output register.
module multi_channel_esc_pulse_generator
  import mcesc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // ms_strobe, button_up, button_down, power_zero, power_one, power_two,
  // power_three, power_present, one zero pad bit
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // esc_lines, motor_zero_speed, timed_out, zero pad bits
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [PHASE_W-1:0]  frame_ticks_r;
  logic [FRAMES_W-1:0] wd_limit_r;
  logic [SPEED_W-1:0]  power_limit_r;
  logic [PULSE_W-1:0]  pulse_base_r;
  logic [7:0]          pulse_mult_r;
  logic                buttons_en_r;
  rpt_cfg_t            rpt_r;

  // pulse state
  logic [SPEED_W-1:0]  speed_r [NUM_MOTORS];
  logic [SPEED_W-1:0]  speed_nxt [NUM_MOTORS];
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [FRAMES_W-1:0] frames_r, frames_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [PULSE_W-1:0]  count_r, count_nxt;
  logic [PULSE_W-1:0]  target_r, target_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic accept;
  logic cfg_we;

  logic                ms_strobe;
  logic [1:0]          btn_sample;
  logic [POWER_W-1:0]  power [PWR_FIELDS];
  logic [PWR_FIELDS-1:0] present;

  btn_ctrl_t           btn_ctrl;
  logic [SPEED_W-1:0]  btn_speed_in;
  logic [SPEED_W-1:0]  btn_speed_out;

  function automatic logic [PULSE_W-1:0] pulse_width(input logic [PULSE_W-1:0] base,
                                                     input logic [SPEED_W-1:0] s,
                                                     input logic [7:0] mult);
    logic [PULSE_W-1:0] prod;
    logic [PULSE_W:0]   sum;
    prod = PULSE_W'(s) * PULSE_W'(mult);
    sum  = {1'b0, base} + {1'b0, prod};
    pulse_width = sum[PULSE_W] ? '1 : sum[PULSE_W-1:0];
  endfunction

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign ms_strobe  = in_tdata[0];
  assign btn_sample = {in_tdata[1], in_tdata[2]};
  assign power[0]   = in_tdata[18:3];
  assign power[1]   = in_tdata[34:19];
  assign power[2]   = in_tdata[50:35];
  assign power[3]   = in_tdata[66:51];
  assign present    = in_tdata[70:67];

  assign btn_ctrl.fire   = accept && !in_tuser && ms_strobe && buttons_en_r;
  assign btn_ctrl.sample = btn_sample;

  mcesc_buttons u_buttons (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (btn_ctrl),
    .rpt     (rpt_r),
    .speed_i (btn_speed_in),
    .speed_o (btn_speed_out)
  );

  always_comb begin
    logic [CH_W-1:0]    next_ch;
    logic [LINES_W-1:0] lines;
    logic [PULSE_W-1:0] pc;
    for (int i = 0; i < NUM_MOTORS; i++) speed_nxt[i] = speed_r[i];
    phase_nxt  = phase_r;
    frames_nxt = frames_r;
    ch_nxt     = ch_r;
    count_nxt  = count_r;
    target_nxt = target_r;
    next_ch    = ch_r + 1'b1;
    pc         = count_r + 1'b1;
    if (in_tuser) begin
      for (int i = 0; i < NUM_MOTORS && i < PWR_FIELDS; i++) begin
        if (present[i] && power[i][POWER_W-1:SPEED_W] == '0) begin
          speed_nxt[i] = (power[i][SPEED_W-1:0] > power_limit_r) ?
                         power_limit_r : power[i][SPEED_W-1:0];
        end
      end
      frames_nxt = '0;
    end else begin
      if (ch_r < CH_W'(NUM_MOTORS)) begin
        count_nxt = pc;
        if (pc >= target_r) begin
          ch_nxt    = next_ch;
          count_nxt = '0;
          if (next_ch < CH_W'(NUM_MOTORS)) begin
            target_nxt = pulse_width(pulse_base_r, speed_r[next_ch[IDX_W-1:0]],
                                     pulse_mult_r);
          end
        end
      end
      if (ms_strobe) begin
        if (phase_r == frame_ticks_r) begin
          // new frame: cuts any pulse in progress short
          phase_nxt  = '0;
          ch_nxt     = '0;
          count_nxt  = '0;
          target_nxt = pulse_width(pulse_base_r, speed_r[0], pulse_mult_r);
          if (frames_r > wd_limit_r) begin
            for (int i = 0; i < NUM_MOTORS; i++) speed_nxt[i] = '0;
          end else if (frames_r != FRAMES_SAT) begin
            frames_nxt = frames_r + 1'b1;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
    end
    btn_speed_in = speed_nxt[0];
    if (btn_ctrl.fire) speed_nxt[0] = btn_speed_out;

    lines = '0;
    for (int i = 0; i < LINES_W && i < NUM_MOTORS; i++) begin
      lines[i] = (ch_nxt == CH_W'(i));
    end
    out_data_nxt = {3'b000, (frames_nxt > wd_limit_r), speed_nxt[0], lines};
    out_valid_nxt = accept || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOTORS; i++) speed_r[i] <= '0;
      phase_r     <= '0;
      frames_r    <= '0;
      ch_r        <= CH_W'(NUM_MOTORS);
      count_r     <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        for (int i = 0; i < NUM_MOTORS; i++) speed_r[i] <= speed_nxt[i];
        phase_r  <= phase_nxt;
        frames_r <= frames_nxt;
        ch_r     <= ch_nxt;
        count_r  <= count_nxt;
        target_r <= target_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ticks_r   <= FRAME_TICKS_RST;
      wd_limit_r      <= WATCHDOG_LIMIT_RST;
      power_limit_r   <= POWER_LIMIT_RST;
      pulse_base_r    <= PULSE_BASE_RST;
      pulse_mult_r    <= PULSE_MULT_RST;
      buttons_en_r    <= 1'b0;
      rpt_r.delay     <= REPEAT_DELAY_RST;
      rpt_r.step_back <= REPEAT_STEP_BACK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_TICKS:      frame_ticks_r   <= cfg_data[PHASE_W-1:0];
        REG_WATCHDOG_LIMIT:   wd_limit_r      <= cfg_data[FRAMES_W-1:0];
        REG_POWER_LIMIT:      power_limit_r   <= cfg_data[SPEED_W-1:0];
        REG_PULSE_BASE:       pulse_base_r    <= cfg_data[PULSE_W-1:0];
        REG_PULSE_MULT:       pulse_mult_r    <= cfg_data[7:0];
        REG_BUTTONS_ENABLE:   buttons_en_r    <= cfg_data[0];
        REG_REPEAT_DELAY:     rpt_r.delay     <= cfg_data[HOLD_W-1:0];
        REG_REPEAT_STEP_BACK: rpt_r.step_back <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end else if (accept && in_tuser) begin
      // a command hands control back from the buttons unless a cfg write wins
      buttons_en_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
